// ===== hdl/pcmf_pkg.sv =====
// pcmf_pkg: shared types, constants and the integer-to-single conversion
// used by the pcm-to-float sample converter; no dependencies
package pcmf_pkg;

  localparam int MaxChannelsDefault = 8;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } pcmf_in_t;

  typedef struct packed {
    logic [31:0] float_word;
    logic [2:0]  channel_slot;
    logic        last_sample;
    logic        format_error;
  } pcmf_out_t;

  typedef enum logic [1:0] {
    REG_FLOAT_INPUT   = 2'd0,
    REG_SAMPLE_BITS   = 2'd1,
    REG_CHANNEL_COUNT = 2'd2
  } pcmf_reg_t;

  typedef struct packed {
    logic       float_input;
    logic [5:0] sample_bits;
    logic [3:0] channel_count;
  } pcmf_cfg_t;

  // leading one position of a 32-bit magnitude
  function automatic logic [4:0] lead_one(input logic [31:0] v);
    logic [4:0] p;
    p = 5'd0;
    for (int i = 0; i < 32; i++) begin
      if (v[i]) p = 5'(i);
    end
    return p;
  endfunction

  // signed v times 2^-scale as an ieee single, round to nearest even
  function automatic logic [31:0] int_to_single(input logic [31:0] v, input logic [4:0] scale);
    logic        sgn;
    logic [31:0] mag;
    logic [31:0] norm;
    logic [4:0]  p;
    logic [24:0] mant;
    logic        rnd;
    logic        sticky;
    logic [7:0]  expo;
    sgn = v[31];
    mag = sgn ? (~v + 32'd1) : v;
    p = lead_one(mag);
    norm = mag << (5'd31 - p);
    sticky = |norm[6:0];
    rnd = norm[7] && (sticky || norm[8]);
    mant = {1'b0, norm[31:8]} + {24'd0, rnd};
    expo = 8'd127 + {3'd0, p} - {3'd0, scale} + {7'd0, mant[24]};
    if (mag == 32'd0) return 32'd0;
    return {sgn, expo, mant[24] ? mant[23:1] : mant[22:0]};
  endfunction

endpackage

// ===== hdl/pcmf_regs.sv =====
// pcmf_regs: apb configuration registers of the converter
// depends on pcmf_pkg
module pcmf_regs import pcmf_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output pcmf_cfg_t   cfg
);
  pcmf_cfg_t cfg_r;
  logic [1:0] idx;
  assign idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{float_input: 1'b0, sample_bits: 6'd16, channel_count: 4'd2};
    end else if (psel && penable && pwrite) begin
      unique case (idx)
        REG_FLOAT_INPUT:   cfg_r.float_input <= pwdata[0];
        REG_SAMPLE_BITS:   cfg_r.sample_bits <= pwdata[5:0];
        REG_CHANNEL_COUNT: cfg_r.channel_count <= pwdata[3:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_FLOAT_INPUT:   prdata = {31'd0, cfg_r.float_input};
      REG_SAMPLE_BITS:   prdata = {26'd0, cfg_r.sample_bits};
      REG_CHANNEL_COUNT: prdata = {28'd0, cfg_r.channel_count};
      default:           prdata = 32'd0;
    endcase
  end

  assign cfg = cfg_r;
endmodule

// ===== hdl/pcmf_core.sv =====
// pcmf_core: byte gathering, channel tracking and conversion to single
// depends on pcmf_pkg
module pcmf_core import pcmf_pkg::*; #(
  parameter int MAX_CHANNELS = MaxChannelsDefault
) (
  input  logic      clk,
  input  logic      rst_n,
  input  pcmf_cfg_t cfg,
  input  logic      take,
  input  pcmf_in_t  word_in,
  output logic      res_valid,
  output pcmf_out_t res
);
  localparam logic [5:0] MaxCh = 6'(MAX_CHANNELS);

  logic [23:0] gath_r, gath_nxt;
  logic [1:0]  bpos_r, bpos_nxt;
  logic [2:0]  cpos_r, cpos_nxt;
  logic [2:0]  need;
  logic [31:0] word;
  logic [5:0]  eff;
  logic [5:0]  cinc;

  always_comb begin
    need = 3'd0;
    if (cfg.float_input && cfg.sample_bits == 6'd32) need = 3'd4;
    else if (!cfg.float_input && (cfg.sample_bits == 6'd16 || cfg.sample_bits == 6'd24
             || cfg.sample_bits == 6'd32)) need = cfg.sample_bits[5:3];
  end

  always_comb begin
    eff = {2'd0, cfg.channel_count};
    if (eff == 6'd0) eff = 6'd1;
    if (eff > MaxCh) eff = MaxCh;
    cinc = {3'd0, cpos_r} + 6'd1;
    word = {8'd0, gath_r} | ({24'd0, word_in.data_byte} << {bpos_r, 3'b000});
    if (need == 3'd2) word = {{16{word[15]}}, word[15:0]};
    else if (need == 3'd3) word = {{8{word[23]}}, word[23:0]};
    gath_nxt = gath_r;
    bpos_nxt = bpos_r;
    cpos_nxt = cpos_r;
    res_valid = 1'b0;
    res = '0;
    res.last_sample = word_in.buffer_end;
    if (need == 3'd0) begin
      res_valid = 1'b1;
      res.format_error = 1'b1;
      gath_nxt = '0;
      bpos_nxt = '0;
    end else if ({1'b0, bpos_r} + 3'd1 < need) begin
      gath_nxt = word[23:0];
      bpos_nxt = bpos_r + 2'd1;
    end else begin
      res_valid = 1'b1;
      res.float_word = cfg.float_input ? word
                       : int_to_single(word, 5'({need, 3'b000} - 6'd1));
      res.channel_slot = cpos_r;
      cpos_nxt = (cinc >= eff) ? 3'd0 : cinc[2:0];
      gath_nxt = '0;
      bpos_nxt = '0;
    end
    if (word_in.buffer_end) begin
      gath_nxt = '0;
      bpos_nxt = '0;
      cpos_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gath_r <= '0;
      bpos_r <= '0;
      cpos_r <= '0;
    end else if (take) begin
      gath_r <= gath_nxt;
      bpos_r <= bpos_nxt;
      cpos_r <= cpos_nxt;
    end
  end

  a_cpos_range: assert property (@(posedge clk) disable iff (!rst_n)
    {3'd0, cpos_r} < MaxCh) else $error("channel position out of range");
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    take && word_in.buffer_end |=> bpos_r == 2'd0 && cpos_r == 3'd0)
    else $error("buffer end did not clear state");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.format_error |-> res.float_word == 32'd0)
    else $error("error result carries data");
endmodule

// ===== hdl/pcm_to_float_sample_converter.sv =====
// pcm_to_float_sample_converter: top level with input register and skid output
// depends on pcmf_pkg, pcmf_regs, pcmf_core
// usage:
//   in_ channel carries one byte word (data_byte, buffer_end) per handshake;
//   a word is taken when in_valid is high and in_stall is low.
//   out_ channel carries one result word (float_word, channel_slot,
//   last_sample, format_error) on out_valid, held while out_stall is high.
//   configuration through the apb port: float_input at 0x0, sample_bits at
//   0x4, channel_count at 0x8; write only while idle.
//   a byte that completes a sample is held in the input register, and its
//   result is then captured in the result register.
//   throughput: one byte per cycle while in_stall is low, set by the
//   combinational conversion path between the two registers.
//   a receiver stall fills the result register and one skid entry; in_stall
//   rises only when both are full.
//   reset clears all gathering state, the pipeline and the registers to
//   16-bit stereo integer pcm.
module pcm_to_float_sample_converter import pcmf_pkg::*; #(
  parameter int MAX_CHANNELS = MaxChannelsDefault
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  pcmf_in_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output pcmf_out_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  pcmf_cfg_t cfg;
  logic      iv_r;
  pcmf_in_t  id_r;
  logic      ov_r, sv_r;
  pcmf_out_t od_r, sd_r;
  logic      res_valid;
  pcmf_out_t res;
  logic      take;

  assign cfg_pready = 1'b1;

  pcmf_regs u_regs (
    .clk(clk), .rst_n(rst_n), .psel(cfg_psel), .penable(cfg_penable),
    .pwrite(cfg_pwrite), .paddr(cfg_paddr), .pwdata(cfg_pwdata),
    .prdata(cfg_prdata), .cfg(cfg)
  );

  pcmf_core #(.MAX_CHANNELS(MAX_CHANNELS)) u_core (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .take(take), .word_in(id_r),
    .res_valid(res_valid), .res(res)
  );

  // stage can advance unless a result waits behind a full skid
  assign take = iv_r && !sv_r;
  assign in_stall = sv_r;
  assign out_valid = ov_r;
  assign out_data = od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r <= 1'b0;
      ov_r <= 1'b0;
      sv_r <= 1'b0;
    end else begin
      if (!sv_r) iv_r <= in_valid;
      if (!ov_r || !out_stall) begin
        ov_r <= sv_r || (take && res_valid);
        sv_r <= 1'b0;
      end else if (take && res_valid) begin
        sv_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!sv_r) id_r <= in_data;
    if (!ov_r || !out_stall) od_r <= sv_r ? sd_r : res;
    else if (take && res_valid) sd_r <= res;
  end

  a_skid_needs_out: assert property (@(posedge clk) disable iff (!rst_n)
    sv_r |-> ov_r) else $error("skid full with empty output");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && out_stall |=> ov_r) else $error("result dropped under stall");
  a_no_take_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    sv_r |-> !take) else $error("item advanced with skid full");
endmodule

// ===== bench/pcm_to_float_sample_converter_test.sv =====
// pcm_to_float_sample_converter_test: self-checking bench for the pcm-to-float converter
// drives byte words and apb writes, predicts float words, depends on pcmf_pkg and the rtl
module pcm_to_float_sample_converter_test;
  import pcmf_pkg::*;

  localparam int WatchLimit = 4000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  pcmf_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  pcmf_out_t out_data;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [3:0] cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  pcm_to_float_sample_converter uut (.*);

  always #4 clk = ~clk;

  pcmf_in_t byte_queue[$];
  pcmf_out_t sample_queue[$];
  int fail_count = 0;
  int watch_count = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;

  // predictor state
  logic       float_sel = 1'b0;
  logic [5:0] width_bits = 6'd16;
  logic [3:0] chan_total = 4'd2;
  logic [23:0] gather_reg = '0;
  logic [1:0]  gather_pos = '0;
  logic [2:0]  chan_pos = '0;

  function automatic logic [31:0] scaled_single(input logic [31:0] v, input int scale);
    logic        sgn;
    logic [31:0] mag;
    logic [31:0] mant;
    logic [31:0] rem;
    logic [31:0] half;
    int pos;
    int sh;
    sgn = v[31];
    mag = sgn ? (~v + 32'd1) : v;
    if (mag == 0) return 32'd0;
    pos = 0;
    for (int i = 0; i < 32; i++) if (mag[i]) pos = i;
    if (pos <= 23) begin
      mant = mag << (23 - pos);
    end else begin
      sh = pos - 23;
      rem = mag & ((32'd1 << sh) - 1);
      half = 32'd1 << (sh - 1);
      mant = mag >> sh;
      if (rem > half || (rem == half && mant[0])) mant++;
      if (mant == 32'h0100_0000) begin
        mant = mant >> 1;
        pos++;
      end
    end
    return {sgn, 8'(pos + 127 - scale), mant[22:0]};
  endfunction

  task automatic predict_sample(input pcmf_in_t w);
    int need;
    int nb;
    logic [31:0] word;
    pcmf_out_t r;
    int eff;
    need = 0;
    if (float_sel && width_bits == 6'd32) need = 4;
    else if (!float_sel && (width_bits == 16 || width_bits == 24 || width_bits == 32))
      need = width_bits / 8;
    if (need == 0) begin
      r = '0;
      r.last_sample = w.buffer_end;
      r.format_error = 1'b1;
      sample_queue.push_back(r);
      gather_reg = '0;
      gather_pos = '0;
      if (w.buffer_end) chan_pos = '0;
      return;
    end
    if (gather_pos + 1 < need) begin
      gather_reg = gather_reg | (24'(w.data_byte) << (8 * gather_pos));
      gather_pos = gather_pos + 2'd1;
    end else begin
      word = 32'(gather_reg) | (32'(w.data_byte) << (8 * gather_pos));
      if (need < 4) begin
        nb = 8 * need;
        word = word & ((32'd1 << nb) - 1);
        if (word[nb - 1]) word = word | ~((32'd1 << nb) - 1);
      end
      if (!float_sel) word = scaled_single(word, 8 * need - 1);
      r.float_word = word;
      r.channel_slot = chan_pos;
      r.last_sample = w.buffer_end;
      r.format_error = 1'b0;
      sample_queue.push_back(r);
      eff = chan_total == 0 ? 1 : (chan_total > 8 ? 8 : chan_total);
      chan_pos = (chan_pos + 1 >= eff) ? 3'd0 : chan_pos + 3'd1;
      gather_reg = '0;
      gather_pos = '0;
    end
    if (w.buffer_end) begin
      gather_reg = '0;
      gather_pos = '0;
      chan_pos = '0;
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    fail_count++;
  endtask

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        predict_sample(in_data);
      end
      if (!in_valid || !in_stall) begin
        if (byte_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_data <= byte_queue.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor and watchdog
  always @(posedge clk) begin
    pcmf_out_t want;
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) watch_count <= 0;
      else watch_count <= watch_count + 1;
      if (watch_count > WatchLimit) begin
        $display("FAILURE");
        $finish;
      end
      if (out_valid && !out_stall) begin
        if (sample_queue.size() == 0) begin
          report_mismatch("unexpected word", out_data.float_word, 0);
        end else begin
          want = sample_queue.pop_front();
          if (out_data.float_word !== want.float_word)
            report_mismatch("float_word", out_data.float_word, want.float_word);
          if (out_data.channel_slot !== want.channel_slot)
            report_mismatch("channel_slot", 32'(out_data.channel_slot), 32'(want.channel_slot));
          if (out_data.last_sample !== want.last_sample)
            report_mismatch("last_sample", 32'(out_data.last_sample), 32'(want.last_sample));
          if (out_data.format_error !== want.format_error)
            report_mismatch("format_error", 32'(out_data.format_error),
                            32'(want.format_error));
        end
      end
    end
  end

  task automatic drain();
    while (byte_queue.size() > 0 || in_valid || sample_queue.size() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(input pcmf_reg_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_psel <= 1'b1;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= 4'(4 * idx);
    cfg_pwdata <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    case (idx)
      REG_FLOAT_INPUT: float_sel = val[0];
      REG_SAMPLE_BITS: width_bits = val[5:0];
      default: chan_total = val[3:0];
    endcase
  endtask

  task automatic push_byte(input logic [7:0] b, input logic e);
    pcmf_in_t w;
    w.data_byte = b;
    w.buffer_end = e;
    byte_queue.push_back(w);
  endtask

  task automatic random_bytes(input int n);
    for (int i = 0; i < n; i++) push_byte(8'($urandom), $urandom_range(40) == 0);
  endtask

  initial begin
    logic [5:0] widths[7];
    logic [3:0] chans[7];
    logic       fsel[7];
    widths = '{16, 24, 32, 32, 16, 8, 0};
    fsel = '{0, 0, 0, 1, 1, 0, 0};
    chans = '{2, 8, 1, 0, 15, 3, 5};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    // directed extremes at reset setting, 16-bit stereo
    push_byte(8'h00, 0); push_byte(8'h80, 0);
    push_byte(8'hff, 0); push_byte(8'h7f, 0);
    push_byte(8'hff, 0); push_byte(8'hff, 0);
    push_byte(8'h01, 0); push_byte(8'h00, 1);
    push_byte(8'h55, 1);
    push_byte(8'haa, 0); push_byte(8'h00, 0);
    drain();
    write_reg(REG_SAMPLE_BITS, 32);
    // extreme and exact values for 32-bit pcm, then a partial sample cut by buffer end
    push_byte(8'h80, 0); push_byte(8'hff, 0); push_byte(8'hff, 0); push_byte(8'h7f, 0);
    push_byte(8'h00, 0); push_byte(8'h00, 0); push_byte(8'h00, 0); push_byte(8'h80, 0);
    push_byte(8'hc0, 0); push_byte(8'hff, 0); push_byte(8'hff, 0); push_byte(8'hff, 1);
    push_byte(8'h01, 0); push_byte(8'h02, 1);
    drain();
    for (int ph = 0; ph < 28; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0; stall_pct = 0; end
        1: begin send_idle_pct = 71; stall_pct = 0; end
        2: begin send_idle_pct = 0; stall_pct = 71; end
        default: begin send_idle_pct = 26; stall_pct = 26; end
      endcase
      write_reg(REG_FLOAT_INPUT, 32'(fsel[ph % 7]));
      write_reg(REG_SAMPLE_BITS, 32'(widths[ph % 7]));
      write_reg(REG_CHANNEL_COUNT, 32'(chans[(ph / 7 + ph) % 7]));
      random_bytes(widths[ph % 7] == 0 || widths[ph % 7] == 8 ? 20 : 68);
      drain();
    end
    // mid-sample format change
    send_idle_pct = 0; stall_pct = 0;
    write_reg(REG_FLOAT_INPUT, 0);
    write_reg(REG_SAMPLE_BITS, 32);
    write_reg(REG_CHANNEL_COUNT, 8);
    push_byte(8'h12, 0); push_byte(8'h34, 0); push_byte(8'h56, 0); push_byte(8'h78, 0);
    push_byte(8'h9a, 0); push_byte(8'hbc, 0);
    drain();
    write_reg(REG_SAMPLE_BITS, 16);
    write_reg(REG_CHANNEL_COUNT, 1);
    random_bytes(10);
    drain();
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
